// File: design/dmsp_pkg.sv
// ----------------------------------------------------------------------------
// Drive mixer package
// Register map, mode codes, reset values and the arithmetic helpers shared by
// the drive mixer that turns stick values into servo pulse widths.
// ----------------------------------------------------------------------------
package dmsp_pkg;

    localparam int AXIS_W   = 8;
    localparam int MIX_W    = 10;
    localparam int PULSE_W  = 12;
    localparam int OUT_W    = 13;
    localparam int OFFSET_W = 9;
    localparam int PROD_W   = 20;
    localparam int MOTORS   = 4;

    localparam logic [PULSE_W-1:0] RESET_MIN_PULSE = 12'd1000;
    localparam logic [PULSE_W-1:0] RESET_MAX_PULSE = 12'd2000;

    localparam logic signed [MIX_W-1:0] MOTOR_MIN = -10'sd128;
    localparam logic signed [MIX_W-1:0] MOTOR_MAX = 10'sd127;

    typedef enum logic [1:0] {
        REG_DRIVE_MODE   = 2'd0,
        REG_REVERSE_MASK = 2'd1,
        REG_MIN_PULSE    = 2'd2,
        REG_MAX_PULSE    = 2'd3
    } reg_index_t;

    typedef enum logic [1:0] {
        MODE_TANK      = 2'd0,
        MODE_ARCADE    = 2'd1,
        MODE_HOLONOMIC = 2'd2,
        MODE_SPARE     = 2'd3
    } drive_mode_t;

    typedef struct packed {
        logic [PROD_W-1:0] prod;
        logic              zero;
    } motor_term_t;

    function automatic logic signed [AXIS_W-1:0] saturate(input logic signed [MIX_W-1:0] v);
        logic signed [AXIS_W-1:0] r;
        if (v < MOTOR_MIN)
        begin
            r = -8'sd128;
        end
        else if (v > MOTOR_MAX)
        begin
            r = 8'sd127;
        end
        else
        begin
            r = v[AXIS_W-1:0];
        end
        return r;
    endfunction

    // Exact floor(x / 255) for x below 2^24, as x * ceil(2^32 / 255) >> 32.
    // The constant 0x1010102 is built from four shifted copies of x.
    function automatic logic [OUT_W-1:0] div255(input logic [PROD_W-1:0] x);
        logic [45:0] xw;
        logic [45:0] acc;
        xw  = {26'b0, x};
        acc = (xw << 24) + (xw << 16) + (xw << 8) + (xw << 1);
        return acc[44:32];
    endfunction

endpackage

// File: design/drive_mixer_to_servo_pulse.sv
// ----------------------------------------------------------------------------
// Drive mixer to servo pulse
// Mixes three stick values into four motor values (tank, arcade or mecanum),
// saturates, applies per-motor reversal and maps each onto a servo pulse width.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle through an input register, a product register
// and an output register; backpressure stalls only the stages that are full.
// Reset: rst_n clears the stage valid bits and loads the registers with
// tank mode, no reversal and a 1000 to 2000 microsecond pulse range.
module drive_mixer_to_servo_pulse
    import dmsp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // forward_axis [7:0], turn_axis [15:8], strafe_axis [23:16]
    input  logic [23:0] s_axis_tdata,

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // front_left_pulse [12:0], back_left_pulse [25:13],
    // front_right_pulse [38:26], back_right_pulse [51:39], zeros [55:52]
    output logic [55:0] m_axis_tdata,
    // range_error [0]
    output logic        m_axis_tuser,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [1:0]         drive_mode_reg;
    logic [MOTORS-1:0]  reverse_mask_reg;
    logic [PULSE_W-1:0] min_pulse_reg;
    logic [PULSE_W-1:0] max_pulse_reg;

    reg_index_t         reg_index;
    logic               cfg_write;

    logic                     v1_reg;
    logic signed [AXIS_W-1:0] forward_reg;
    logic signed [AXIS_W-1:0] turn_reg;
    logic signed [AXIS_W-1:0] strafe_reg;

    logic                     v2_reg;
    motor_term_t              term_reg [MOTORS];
    motor_term_t              term_next [MOTORS];

    logic                     v3_reg;
    logic [OUT_W-1:0]         pulse_reg [MOTORS];
    logic [OUT_W-1:0]         pulse_next [MOTORS];
    logic                     error_reg;
    logic                     error_next;

    logic                     ready2;
    logic                     ready3;

    logic signed [MIX_W-1:0]  f_ext;
    logic signed [MIX_W-1:0]  t_ext;
    logic signed [MIX_W-1:0]  s_ext;
    logic signed [AXIS_W-1:0] mix [MOTORS];
    logic [PULSE_W-1:0]       span;
    logic [OUT_W-1:0]         midpoint;

    // Configuration port.
    assign pready    = 1'b1;
    assign reg_index = reg_index_t'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drive_mode_reg   <= MODE_TANK;
            reverse_mask_reg <= '0;
            min_pulse_reg    <= RESET_MIN_PULSE;
            max_pulse_reg    <= RESET_MAX_PULSE;
        end
        else if (cfg_write)
        begin
            case (reg_index)
                REG_DRIVE_MODE:   drive_mode_reg   <= pwdata[1:0];
                REG_REVERSE_MASK: reverse_mask_reg <= pwdata[MOTORS-1:0];
                REG_MIN_PULSE:    min_pulse_reg    <= pwdata[PULSE_W-1:0];
                REG_MAX_PULSE:    max_pulse_reg    <= pwdata[PULSE_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_index)
            REG_DRIVE_MODE:   prdata = {30'b0, drive_mode_reg};
            REG_REVERSE_MASK: prdata = {28'b0, reverse_mask_reg};
            REG_MIN_PULSE:    prdata = {20'b0, min_pulse_reg};
            REG_MAX_PULSE:    prdata = {20'b0, max_pulse_reg};
            default:          prdata = '0;
        endcase
    end

    // Pipeline handshake.
    assign ready3        = !v3_reg || m_axis_tready;
    assign ready2        = !v2_reg || ready3;
    assign s_axis_tready = !v1_reg || ready2;

    // Stage 2: mix, saturate, reverse and multiply by the pulse span.
    assign f_ext = MIX_W'(forward_reg);
    assign t_ext = MIX_W'(turn_reg);
    assign s_ext = MIX_W'(strafe_reg);
    assign span  = max_pulse_reg - min_pulse_reg;

    always_comb
    begin
        logic signed [OFFSET_W-1:0] v9;
        logic [OFFSET_W-1:0]        offset;
        case (drive_mode_t'(drive_mode_reg))
            MODE_TANK:
            begin
                mix[0] = forward_reg;
                mix[1] = forward_reg;
                mix[2] = turn_reg;
                mix[3] = turn_reg;
            end
            MODE_ARCADE:
            begin
                mix[0] = saturate(f_ext - t_ext);
                mix[1] = saturate(f_ext - t_ext);
                mix[2] = saturate(f_ext + t_ext);
                mix[3] = saturate(f_ext + t_ext);
            end
            default:
            begin
                mix[0] = saturate(f_ext - t_ext - s_ext);
                mix[1] = saturate(f_ext - t_ext + s_ext);
                mix[2] = saturate(f_ext + t_ext + s_ext);
                mix[3] = saturate(f_ext + t_ext - s_ext);
            end
        endcase
        for (int k = 0; k < MOTORS; k++)
        begin
            v9 = OFFSET_W'(mix[k]);
            if (reverse_mask_reg[k])
            begin
                v9 = -v9;
            end
            offset            = v9 + 9'd128;
            term_next[k].zero = (mix[k] == '0);
            term_next[k].prod = {11'b0, offset} * {8'b0, span};
        end
    end

    // Stage 3: divide by 255, add the minimum or take the midpoint; zero on error.
    assign midpoint   = OUT_W'(({1'b0, min_pulse_reg} + {1'b0, max_pulse_reg}) >> 1);
    assign error_next = (min_pulse_reg == '0) || (min_pulse_reg >= max_pulse_reg);

    always_comb
    begin
        for (int k = 0; k < MOTORS; k++)
        begin
            if (error_next)
            begin
                pulse_next[k] = '0;
            end
            else if (term_reg[k].zero)
            begin
                pulse_next[k] = midpoint;
            end
            else
            begin
                pulse_next[k] = div255(term_reg[k].prod) + {1'b0, min_pulse_reg};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                v1_reg <= s_axis_tvalid;
            end
            if (ready2)
            begin
                v2_reg <= v1_reg;
            end
            if (ready3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            forward_reg <= s_axis_tdata[7:0];
            turn_reg    <= s_axis_tdata[15:8];
            strafe_reg  <= s_axis_tdata[23:16];
        end
        if (v1_reg && ready2)
        begin
            term_reg <= term_next;
        end
        if (v2_reg && ready3)
        begin
            pulse_reg <= pulse_next;
            error_reg <= error_next;
        end
    end

    assign m_axis_tvalid = v3_reg;
    assign m_axis_tdata  = {4'b0, pulse_reg[3], pulse_reg[2], pulse_reg[1], pulse_reg[0]};
    assign m_axis_tuser  = error_reg;

`ifndef SYNTH
    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[51:0] == '0))
        else $error("range error item carries nonzero pulses");

    a_stage1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && !ready2) |-> !s_axis_tready)
        else $error("input taken while the first stage is blocked");

    a_stage2_move: assert property (@(posedge clk) disable iff (!rst_n)
        (v2_reg && ready3) |=> v3_reg)
        else $error("item lost between product and output stage");

    a_input_load: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> v1_reg)
        else $error("accepted item did not enter the first stage");
`endif

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Drive mixer to servo pulse testbench
// Streams stick items through the mixer under a series of register settings
// and checks every pulse item field by field against typed values or a bench
// predictor, with random stalls on both streams and one long output hold.
// ----------------------------------------------------------------------------
module testbench
    import dmsp_pkg::*;
();

    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_PHASES = 16;
    localparam int PHASE_ITEMS   = 50;
    localparam int HOLD_CYCLES   = 120;
    localparam int DRAIN_CYCLES  = 10;

    typedef struct packed {
        logic        err;
        logic [12:0] br;
        logic [12:0] fr;
        logic [12:0] bl;
        logic [12:0] fl;
    } pulse_set_t;

    typedef struct {
        logic [1:0]  mode;
        logic [3:0]  mask;
        logic [11:0] lo;
        logic [11:0] hi;
        logic [23:0] axes;
        bit          typed;
        pulse_set_t  want;
    } stick_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [55:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    pulse_set_t  pending_pulses[$];
    stick_row_t  stick_rows[$];

    logic [1:0]  cfg_mode;
    logic [3:0]  cfg_mask;
    logic [11:0] cfg_min;
    logic [11:0] cfg_max;

    int          err_count;
    int          items_sent;
    int          results_checked;
    int          cycle_count;
    bit          hold_req;
    bit          hold_done;

    drive_mixer_to_servo_pulse dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic report(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        err_count++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
        begin
            report($sformatf("%s got %0d expected %0d", name, got, want));
        end
    endtask

    function automatic int clamp_motor(input int v);
        if (v < -128)
        begin
            return -128;
        end
        if (v > 127)
        begin
            return 127;
        end
        return v;
    endfunction

    function automatic logic [12:0] servo_pulse(input int v, input bit rev);
        int lo;
        int hi;
        int p;
        logic [12:0] r;
        lo = cfg_min;
        hi = cfg_max;
        if (v == 0)
        begin
            p = (lo + hi) / 2;
        end
        else
        begin
            if (rev)
            begin
                v = -v;
            end
            p = (v + 128) * (hi - lo) / 255 + lo;
        end
        r = p[12:0];
        return r;
    endfunction

    function automatic pulse_set_t predict_pulses(input logic [23:0] axes);
        int f;
        int t;
        int s;
        int m[4];
        pulse_set_t r;
        f = $signed(axes[7:0]);
        t = $signed(axes[15:8]);
        s = $signed(axes[23:16]);
        case (cfg_mode)
            MODE_TANK:
            begin
                m[0] = f;
                m[1] = f;
                m[2] = t;
                m[3] = t;
            end
            MODE_ARCADE:
            begin
                m[0] = clamp_motor(f - t);
                m[1] = m[0];
                m[2] = clamp_motor(f + t);
                m[3] = m[2];
            end
            default:
            begin
                m[0] = clamp_motor(f - t - s);
                m[1] = clamp_motor(f - t + s);
                m[2] = clamp_motor(f + t + s);
                m[3] = clamp_motor(f + t - s);
            end
        endcase
        r = '0;
        if (cfg_min == 12'd0 || cfg_min >= cfg_max)
        begin
            r.err = 1'b1;
        end
        else
        begin
            r.fl = servo_pulse(m[0], cfg_mask[0]);
            r.bl = servo_pulse(m[1], cfg_mask[1]);
            r.fr = servo_pulse(m[2], cfg_mask[2]);
            r.br = servo_pulse(m[3], cfg_mask[3]);
        end
        return r;
    endfunction

    function automatic logic [7:0] rand_axis();
        case ($urandom_range(0, 7))
            0: return 8'h80;
            1: return 8'h7F;
            2: return 8'h00;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic add_row(input int mode, input int mask, input int lo, input int hi,
                           input int f, input int t, input int s,
                           input bit typed, input int fl, input int bl,
                           input int fr, input int br, input int err);
        stick_row_t r;
        r.mode     = 2'(mode);
        r.mask     = 4'(mask);
        r.lo       = 12'(lo);
        r.hi       = 12'(hi);
        r.axes     = {8'(s), 8'(t), 8'(f)};
        r.typed    = typed;
        r.want.fl  = 13'(fl);
        r.want.bl  = 13'(bl);
        r.want.fr  = 13'(fr);
        r.want.br  = 13'(br);
        r.want.err = 1'(err);
        stick_rows.push_back(r);
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_DRIVE_MODE:   cfg_mode = value[1:0];
            REG_REVERSE_MASK: cfg_mask = value[3:0];
            REG_MIN_PULSE:    cfg_min  = value[11:0];
            REG_MAX_PULSE:    cfg_max  = value[11:0];
            default:          ;
        endcase
    endtask

    task automatic drain();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_pulses.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic configure(input logic [1:0] mode, input logic [3:0] mask,
                             input logic [11:0] lo, input logic [11:0] hi, input bit all);
        if (all || mode != cfg_mode || mask != cfg_mask || lo != cfg_min || hi != cfg_max)
        begin
            drain();
            if (all || mode != cfg_mode)
            begin
                write_reg(REG_DRIVE_MODE, {30'd0, mode});
            end
            if (all || mask != cfg_mask)
            begin
                write_reg(REG_REVERSE_MASK, {28'd0, mask});
            end
            if (all || lo != cfg_min)
            begin
                write_reg(REG_MIN_PULSE, {20'd0, lo});
            end
            if (all || hi != cfg_max)
            begin
                write_reg(REG_MAX_PULSE, {20'd0, hi});
            end
        end
    endtask

    task automatic send_axes(input logic [23:0] axes, input int gap, input pulse_set_t want);
        @(negedge clk);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= axes;
        do @(posedge clk); while (!s_axis_tready);
        pending_pulses.push_back(want);
        items_sent++;
    endtask

    initial
    begin
        int         rx_gap;
        bit         rx_gappy;
        pulse_set_t got;
        pulse_set_t want;
        m_axis_tready = 1'b0;
        rx_gappy      = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_done)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_done = 1'b1;
            end
            if (results_checked % 32 == 0)
            begin
                rx_gappy = ($urandom_range(0, 2) != 0);
            end
            rx_gap = rx_gappy ? $urandom_range(0, 14) : 0;
            if (rx_gap > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (rx_gap) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
            got = {m_axis_tuser, m_axis_tdata[51:39], m_axis_tdata[38:26],
                   m_axis_tdata[25:13], m_axis_tdata[12:0]};
            if (pending_pulses.size() == 0)
            begin
                report($sformatf("pulse item with nothing pending: %h", got));
            end
            else
            begin
                want = pending_pulses.pop_front();
                check_field("front_left_pulse", got.fl, want.fl);
                check_field("back_left_pulse", got.bl, want.bl);
                check_field("front_right_pulse", got.fr, want.fr);
                check_field("back_right_pulse", got.br, want.br);
                check_field("range_error", got.err, want.err);
            end
            results_checked++;
        end
    end

    initial
    begin
        int          gap;
        bit          tx_gappy;
        logic [1:0]  mode;
        logic [3:0]  mask;
        logic [11:0] lo;
        logic [11:0] hi;
        logic [23:0] axes;
        stick_row_t  row;

        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        cfg_mode      = MODE_TANK;
        cfg_mask      = 4'h0;
        cfg_min       = RESET_MIN_PULSE;
        cfg_max       = RESET_MAX_PULSE;

        add_row(MODE_TANK, 4'h0, 1000, 2000, 0, 0, 0, 1, 1500, 1500, 1500, 1500, 0);
        add_row(MODE_TANK, 4'h0, 1000, 2000, -128, 127, 0, 1, 1000, 1000, 2000, 2000, 0);
        add_row(MODE_TANK, 4'h0, 1000, 2000, 127, -128, -128, 1, 2000, 2000, 1000, 1000, 0);
        add_row(MODE_TANK, 4'h0, 1000, 2000, -1, 1, 85, 0, 0, 0, 0, 0, 0);
        add_row(MODE_ARCADE, 4'h0, 1000, 2000, 127, -128, 0, 0, 0, 0, 0, 0, 0);
        add_row(MODE_ARCADE, 4'h0, 1000, 2000, 127, 127, 0, 0, 0, 0, 0, 0, 0);
        add_row(MODE_ARCADE, 4'h0, 1000, 2000, -128, 127, 5, 0, 0, 0, 0, 0, 0);
        add_row(MODE_ARCADE, 4'h0, 1000, 2000, 100, -100, -1, 0, 0, 0, 0, 0, 0);
        add_row(MODE_HOLONOMIC, 4'h0, 1000, 2000, 127, 127, 127, 0, 0, 0, 0, 0, 0);
        add_row(MODE_HOLONOMIC, 4'h0, 1000, 2000, -128, -128, -128, 0, 0, 0, 0, 0, 0);
        add_row(MODE_HOLONOMIC, 4'h0, 1000, 2000, 50, -30, 20, 0, 0, 0, 0, 0, 0);
        add_row(MODE_HOLONOMIC, 4'h0, 1000, 2000, -128, 127, -128, 0, 0, 0, 0, 0, 0);
        add_row(MODE_SPARE, 4'h0, 1000, 2000, 10, 20, 30, 0, 0, 0, 0, 0, 0);
        add_row(MODE_SPARE, 4'h0, 1000, 2000, -128, 0, 127, 0, 0, 0, 0, 0, 0);
        add_row(MODE_TANK, 4'hF, 1000, 2000, -128, -128, 0, 1, 2003, 2003, 2003, 2003, 0);
        add_row(MODE_TANK, 4'hF, 1000, 2000, 127, 127, -1, 0, 0, 0, 0, 0, 0);
        add_row(MODE_TANK, 4'h5, 1000, 2000, -128, 64, 0, 0, 0, 0, 0, 0, 0);
        add_row(MODE_TANK, 4'h0, 1, 4095, -128, 127, 0, 1, 1, 1, 4095, 4095, 0);
        add_row(MODE_TANK, 4'hF, 1, 4095, -128, -128, 0, 0, 0, 0, 0, 0, 0);
        add_row(MODE_TANK, 4'h0, 2000, 2000, 40, -40, 0, 1, 0, 0, 0, 0, 1);
        add_row(MODE_TANK, 4'h0, 4095, 1, 127, -128, 0, 1, 0, 0, 0, 0, 1);
        add_row(MODE_TANK, 4'h0, 0, 2000, 0, 0, 0, 1, 0, 0, 0, 0, 1);
        add_row(MODE_TANK, 4'h0, 4094, 4095, 0, -128, 0, 0, 0, 0, 0, 0, 0);
        add_row(MODE_HOLONOMIC, 4'hA, 1, 2, 3, -7, 99, 0, 0, 0, 0, 0, 0);

        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        foreach (stick_rows[i])
        begin
            row = stick_rows[i];
            configure(row.mode, row.mask, row.lo, row.hi, 1'b0);
            gap = $urandom_range(0, 14);
            send_axes(row.axes, gap, row.typed ? row.want : predict_pulses(row.axes));
        end

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            mode = 2'($urandom_range(0, 3));
            mask = 4'($urandom_range(0, 15));
            case (phase)
                1:
                begin
                    lo = 12'd1;
                    hi = 12'd4095;
                end
                2:
                begin
                    lo = 12'd4094;
                    hi = 12'd4095;
                end
                3:
                begin
                    lo = 12'd4095;
                    hi = 12'd4095;
                end
                default:
                begin
                    if ($urandom_range(0, 7) == 0)
                    begin
                        lo = 12'($urandom_range(0, 4095));
                        hi = 12'($urandom_range(0, lo));
                    end
                    else
                    begin
                        lo = 12'($urandom_range(1, 4094));
                        hi = 12'($urandom_range(lo + 1, 4095));
                    end
                end
            endcase
            configure(mode, mask, lo, hi, 1'b1);
            tx_gappy = ($urandom_range(0, 2) != 0);
            if (phase == 0)
            begin
                hold_req = 1'b1;
                tx_gappy = 1'b0;
            end
            repeat (PHASE_ITEMS)
            begin
                axes = {rand_axis(), rand_axis(), rand_axis()};
                gap  = tx_gappy ? $urandom_range(0, 14) : 0;
                send_axes(axes, gap, predict_pulses(axes));
            end
        end

        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d stick items over %0d directed rows and %0d random settings,",
                 items_sent, stick_rows.size(), RANDOM_PHASES);
        $display("covering all drive modes, reversal masks and valid and invalid ranges; "
                 , "%0d pulse items checked, %0d mismatches.", results_checked, err_count);
        if (err_count == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
